FILE: rtl/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg: shared types and constants for the overwriting ring stack
// Operation codes, transaction structs and sizing of the slot ring.
// ----------------------------------------------------------------------------
package ors_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int FIELD_W     = 32;
   localparam int STORE_W     = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam int LEN_W       = 8;
   localparam int SLOT_W      = STORE_W + LEN_W;
   localparam int FUNC_W      = 2;
   localparam int PEEK_W      = 4;
   localparam int CNT_W       = 5;
   localparam int SUM_W       = CNT_W + 1;
   localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [FIELD_W-1:0] push_data;
      logic [LEN_W-1:0]   push_length;
      logic [PEEK_W-1:0]  peek_index;
   } ors_req_type;

   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] out_data;
      logic [LEN_W-1:0]   out_length;
      logic [CNT_W-1:0]   entry_count;
      logic               is_empty;
   } ors_rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] cap;
      logic [PTR_W-1:0] head;
      logic [CNT_W-1:0] count;
   } ors_status_type;

   function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] value);
      if (value == '0 || value > CNT_W'(DEPTH)) begin
         return CNT_W'(DEPTH);
      end
      return value;
   endfunction

endpackage

FILE: rtl/ors_if.sv
// ----------------------------------------------------------------------------
// ors_if: request and response channels of the overwriting ring stack
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface ors_req_if;
   import ors_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [FIELD_W-1:0] push_data;
   logic [LEN_W-1:0]   push_length;
   logic [PEEK_W-1:0]  peek_index;

   modport source (output valid, output func, output push_data, output push_length,
                   output peek_index, input ready);
   modport sink   (input valid, input func, input push_data, input push_length,
                   input peek_index, output ready);
endinterface

interface ors_rsp_if;
   import ors_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [FIELD_W-1:0] out_data;
   logic [LEN_W-1:0]   out_length;
   logic [CNT_W-1:0]   entry_count;
   logic               is_empty;

   modport source (output valid, output found, output out_data, output out_length,
                   output entry_count, output is_empty, input ready);
   modport sink   (input valid, input found, input out_data, input out_length,
                   input entry_count, input is_empty, output ready);
endinterface

FILE: rtl/ors_stack.sv
// ----------------------------------------------------------------------------
// ors_stack: slot ring, head pointer, entry count and capacity register
// Computes one response per step and commits the pointer and count update.
// ----------------------------------------------------------------------------
module ors_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  ors_pkg::ors_req_type   req,
   input  logic                   cfg_en,
   input  logic [ors_pkg::CNT_W-1:0] cfg_data,
   output ors_pkg::ors_rsp_type   rsp,
   output ors_pkg::ors_status_type status
);
   import ors_pkg::*;

   logic [SLOT_W-1:0]  slots_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   head_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   cap_ff;

   logic [CNT_W-1:0]   sel_n;
   logic [SUM_W-1:0]   raw_idx;
   logic [SUM_W-1:0]   wrap_idx;
   logic [PTR_W-1:0]   rd_idx;
   logic [SLOT_W-1:0]  rd_slot;
   logic [SUM_W-1:0]   head_inc;
   logic               wr_en;
   logic [FIELD_W-1:0] rd_word;

   always_comb begin
      sel_n    = (req.func == FUNC_PEEK) ? CNT_W'(req.peek_index) : '0;
      raw_idx  = SUM_W'(head_ff) + SUM_W'(cap_ff) - SUM_W'(1) - SUM_W'(sel_n);
      wrap_idx = (raw_idx >= SUM_W'(cap_ff)) ? raw_idx - SUM_W'(cap_ff) : raw_idx;
      rd_idx   = wrap_idx[PTR_W-1:0];
      rd_slot  = slots_ff[rd_idx];
      rd_word  = '0;
      rd_word[STORE_W-1:0] = rd_slot[SLOT_W-1:LEN_W];
      head_inc = SUM_W'(head_ff) + SUM_W'(1);

      head_in         = head_ff;
      count_in        = count_ff;
      wr_en           = 1'b0;
      rsp.found       = 1'b0;
      rsp.out_data    = '0;
      rsp.out_length  = '0;

      case (req.func)
         FUNC_PUSH: begin
            wr_en     = 1'b1;
            head_in   = (head_inc >= SUM_W'(cap_ff)) ? '0 : head_inc[PTR_W-1:0];
            if (count_ff < cap_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
            rsp.found = 1'b1;
         end
         FUNC_POP: begin
            if (count_ff != '0) begin
               rsp.found      = 1'b1;
               rsp.out_data   = rd_word;
               rsp.out_length = rd_slot[LEN_W-1:0];
               head_in        = rd_idx;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         FUNC_PEEK: begin
            if (CNT_W'(req.peek_index) < count_ff) begin
               rsp.found      = 1'b1;
               rsp.out_data   = rd_word;
               rsp.out_length = rd_slot[LEN_W-1:0];
            end
         end
         default: begin
         end
      endcase

      rsp.entry_count = count_in;
      rsp.is_empty    = (count_in == '0);

      status.cap   = cap_ff;
      status.head  = head_ff;
      status.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cfg_en) begin
         cap_ff   <= eff_cap(cfg_data);
         head_ff  <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && wr_en && !cfg_en) begin
         slots_ff[head_ff] <= {req.push_data[STORE_W-1:0], req.push_length};
      end
   end

endmodule

FILE: rtl/overwriting_ring_stack.sv
// ----------------------------------------------------------------------------
// overwriting_ring_stack: bounded history stack in a ring of slots
// Push, pop and peek with overwrite of the oldest entry when full.
//
//   channel   direction  handshake             payload
//   req_chan  in         valid/ready           func, push_data, push_length, peek_index
//   rsp_chan  out        valid/ready           found, out_data, out_length,
//                                              entry_count, is_empty
//   csr       in         csr_wr_en             csr_wr_data (capacity)
//
// One transaction per cycle unless the response stalls. An accepted request is
// held in the input register; its slot read and pointer/count update then
// commit with the result register. Synchronous reset empties the stack and
// sets capacity to the full ring. A stalled response holds the result register;
// the input register still fills once, then the request channel stalls too.
// ----------------------------------------------------------------------------
module overwriting_ring_stack (
   input  logic                      clock,
   input  logic                      reset,
   ors_req_if.sink                   req_chan,
   ors_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [ors_pkg::CNT_W-1:0] csr_wr_data
);
   import ors_pkg::*;

   logic           s1_valid_ff;
   ors_req_type    s1_req_ff;
   logic           rsp_valid_ff;
   ors_rsp_type    rsp_ff;
   ors_rsp_type    stack_rsp;
   ors_status_type status;
   logic           advance;
   logic           accept;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= {req_chan.func, req_chan.push_data, req_chan.push_length,
                       req_chan.peek_index};
      end
      if (advance) begin
         rsp_ff <= stack_rsp;
      end
   end

   ors_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .req      (s1_req_ff),
      .cfg_en   (csr_wr_en),
      .cfg_data (csr_wr_data),
      .rsp      (stack_rsp),
      .status   (status)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_ff.found;
   assign rsp_chan.out_data    = rsp_ff.out_data;
   assign rsp_chan.out_length  = rsp_ff.out_length;
   assign rsp_chan.entry_count = rsp_ff.entry_count;
   assign rsp_chan.is_empty    = rsp_ff.is_empty;

   a_count_le_cap : assert property (@(posedge clock) disable iff (reset)
      status.count <= status.cap)
      else $error("entry count above capacity");

   a_head_lt_cap : assert property (@(posedge clock) disable iff (reset)
      CNT_W'(status.head) < status.cap)
      else $error("head pointer outside ring");

   a_cfg_clears : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (status.count == '0))
      else $error("capacity write did not empty the stack");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |->
         (rsp_chan.out_data == '0 && rsp_chan.out_length == '0))
      else $error("miss transaction carries data");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the overwriting ring stack
// Push, pop, peek and the unused operation are driven over the request
// channel at every capacity extreme. A predictor of the ring computes each
// response and the monitor checks them in order, with random gaps on both
// channels, a long response stall and drains between capacity writes.
// ----------------------------------------------------------------------------
module tb_top;
   import ors_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 80;
   localparam int PHASE_ITEMS = 150;
   localparam logic [CNT_W-1:0] PHASE_CAPS [7] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd5, 5'd16};

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   ors_req_if req_chan ();
   ors_rsp_if rsp_chan ();

   overwriting_ring_stack dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ring predictor state
   logic [STORE_W-1:0] ring_data [DEPTH];
   logic [LEN_W-1:0]   ring_len  [DEPTH];
   int unsigned        ring_head  = 0;
   int unsigned        ring_count = 0;
   logic [CNT_W-1:0]   cap_reg    = CAP_RESET;

   ors_req_type pending_ops[$];
   ors_rsp_type expected_rsps[$];

   int unsigned errors       = 0;
   int unsigned cycle_count  = 0;
   bit          no_gaps      = 1'b0;
   int unsigned stall_orders = 0;
   int unsigned stall_served = 0;
   int unsigned stall_left   = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic ors_rsp_type stack_step(input ors_req_type op);
      int unsigned cap;
      int unsigned slot;
      ors_rsp_type r;
      cap = (cap_reg == '0 || cap_reg > CNT_W'(DEPTH)) ? DEPTH : cap_reg;
      r = '0;
      if (ring_head >= cap) ring_head = 0;
      if (ring_count > cap) ring_count = cap;
      case (op.func)
         FUNC_PUSH: begin
            ring_data[ring_head] = op.push_data[STORE_W-1:0];
            ring_len[ring_head]  = op.push_length;
            ring_head = (ring_head + 1 >= cap) ? 0 : ring_head + 1;
            if (ring_count < cap) ring_count++;
            r.found = 1'b1;
         end
         FUNC_POP: begin
            if (ring_count != 0) begin
               slot = (ring_head + cap - 1) % cap;
               r.out_data   = FIELD_W'(ring_data[slot]);
               r.out_length = ring_len[slot];
               r.found      = 1'b1;
               ring_head    = slot;
               ring_count--;
            end
         end
         FUNC_PEEK: begin
            if (op.peek_index < ring_count) begin
               slot = (ring_head + cap - 1 - op.peek_index) % cap;
               r.out_data   = FIELD_W'(ring_data[slot]);
               r.out_length = ring_len[slot];
               r.found      = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.entry_count = CNT_W'(ring_count);
      r.is_empty    = (ring_count == 0);
      return r;
   endfunction

   function automatic void add_op(input logic [FUNC_W-1:0] f, input logic [FIELD_W-1:0] d,
                                 input logic [LEN_W-1:0] len, input logic [PEEK_W-1:0] idx);
      ors_req_type op;
      op.func        = f;
      op.push_data   = d;
      op.push_length = len;
      op.peek_index  = idx;
      pending_ops.push_back(op);
   endfunction

   function automatic void add_random_op(input int unsigned push_pct);
      int unsigned       roll;
      logic [FUNC_W-1:0] f;
      logic [FIELD_W-1:0] d;
      logic [PEEK_W-1:0] idx;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) f = FUNC_PUSH;
      else if (roll < push_pct + (95 - push_pct) / 2) f = FUNC_POP;
      else if (roll < 95) f = FUNC_PEEK;
      else f = FUNC_UNUSED;
      case ($urandom_range(0, 9))
         0: d = '0;
         1: d = '1;
         default: d = $urandom;
      endcase
      idx = $urandom_range(0, 1) ? PEEK_W'($urandom_range(0, 3)) : PEEK_W'($urandom);
      add_op(f, d, LEN_W'($urandom_range(0, 255)), idx);
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_chan.valid || expected_rsps.size() != 0);
   endtask

   task automatic set_capacity(input logic [CNT_W-1:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cap_reg    = value;
      ring_head  = 0;
      ring_count = 0;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic report(input string field, input logic [FIELD_W-1:0] want,
                         input logic [FIELD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rsps.push_back(stack_step('{req_chan.func, req_chan.push_data,
                                                 req_chan.push_length, req_chan.peek_index}));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_ops.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 17)) begin
               req_chan.valid       <= 1'b1;
               req_chan.func        <= pending_ops[0].func;
               req_chan.push_data   <= pending_ops[0].push_data;
               req_chan.push_length <= pending_ops[0].push_length;
               req_chan.peek_index  <= pending_ops[0].peek_index;
               void'(pending_ops.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_served != stall_orders) begin
         rsp_chan.ready <= 1'b0;
         stall_left   <= LONG_STALL;
         stall_served <= stall_served + 1;
      end else begin
         rsp_chan.ready <= no_gaps || ($urandom_range(0, 99) >= 17);
      end
   end

   // response monitor
   always @(posedge clock) begin
      ors_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transaction expected none actual %0h", $time,
                     rsp_chan.out_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            report("found", FIELD_W'(want.found), FIELD_W'(rsp_chan.found));
            report("out_data", want.out_data, rsp_chan.out_data);
            report("out_length", FIELD_W'(want.out_length), FIELD_W'(rsp_chan.out_length));
            report("entry_count", FIELD_W'(want.entry_count), FIELD_W'(rsp_chan.entry_count));
            report("is_empty", FIELD_W'(want.is_empty), FIELD_W'(rsp_chan.is_empty));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int unsigned k;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.func        = FUNC_PUSH;
      req_chan.push_data   = '0;
      req_chan.push_length = '0;
      req_chan.peek_index  = '0;
      rsp_chan.ready       = 1'b0;
      for (k = 0; k < DEPTH; k++) begin
         ring_data[k] = '0;
         ring_len[k]  = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty stack, extremes, peek range at the reset capacity
      @(negedge clock);
      add_op(FUNC_POP, '0, '0, '0);
      add_op(FUNC_PEEK, '0, '0, '0);
      add_op(FUNC_UNUSED, '0, '0, '0);
      add_op(FUNC_PUSH, '1, '1, '0);
      add_op(FUNC_PUSH, '0, '0, '1);
      add_op(FUNC_PUSH, 32'h5a5a_5a5a, 8'h80, 4'h3);
      add_op(FUNC_PEEK, '0, '0, 4'd0);
      add_op(FUNC_PEEK, '0, '0, 4'd2);
      add_op(FUNC_PEEK, '0, '0, 4'd3);
      add_op(FUNC_PEEK, '1, '1, 4'd15);
      add_op(FUNC_UNUSED, '1, '1, '1);
      add_op(FUNC_POP, '1, '1, '1);
      add_op(FUNC_POP, '0, '0, '0);
      add_op(FUNC_POP, '0, '0, '0);
      add_op(FUNC_POP, '0, '0, '0);

      // single-slot ring: overwrite on every push
      set_capacity(5'd1);
      @(negedge clock);
      add_op(FUNC_PUSH, 32'h1111_1111, 8'd1, '0);
      add_op(FUNC_PUSH, 32'h2222_2222, 8'd2, '0);
      add_op(FUNC_PEEK, '0, '0, 4'd0);
      add_op(FUNC_PEEK, '0, '0, 4'd1);
      add_op(FUNC_POP, '0, '0, '0);
      add_op(FUNC_POP, '0, '0, '0);

      for (k = 0; k < 7; k++) begin
         set_capacity(PHASE_CAPS[k]);
         @(negedge clock);
         no_gaps = (k == 4);
         if (k == 2) stall_orders = stall_orders + 1;
         repeat (PHASE_ITEMS) add_random_op((k % 2 == 0) ? 55 : 35);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/ors_pkg.sv
rtl/ors_if.sv
rtl/ors_stack.sv
rtl/overwriting_ring_stack.sv
tb/sv/tb_top.sv
